// ===== hdl/hpt_pkg.sv =====
package hpt_pkg;

    localparam int PIX_W   = 24;
    localparam int GAIN_W  = 24;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int X_W     = 23;            // exposed value, Q7.16 magnitude
    localparam int T_W     = 17;            // Q1.16 fraction, 0..65536
    localparam int NUM_W   = 59;            // dividend
    localparam int DEN_W   = 42;            // divisor
    localparam int QB      = 17;            // quotient bits per division
    localparam int RB      = 17;            // result bits per root
    localparam int SQ_V_W  = 33;            // square root radicand
    localparam int CB_V_W  = 49;            // cube root radicand
    localparam int SQ2_W   = 35;
    localparam int CB3_W   = 52;
    localparam int WIDE_W  = 56;

    // 6 front stages, overflow check, divider, tone select, two root rows,
    // five back-end stages (last one is the output register)
    localparam int LAT = 6 + 1 + QB + 1 + RB + RB + 5;

    localparam logic [T_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [X_W-1:0] MAX_X     = 23'h7FFFFF;
    localparam logic [GAIN_W-1:0] GAIN_RST = 24'd65536;

    localparam logic [17:0] ACES_A  = 18'd164495;
    localparam logic [21:0] ACES_B  = 22'd1966;
    localparam logic [17:0] ACES_C  = 18'd159252;
    localparam logic [21:0] ACES_D  = 22'd38666;
    localparam logic [DEN_W-1:0] ACES_E = 42'd9175 << 16;
    localparam logic [19:0] SRGB_LIN  = 20'd846725;
    localparam logic [16:0] SRGB_GAIN = 17'd69140;
    localparam logic [17:0] SRGB_OFS  = 18'd3604;
    localparam logic [T_W-1:0] SRGB_KNEE = 17'd205;

    localparam logic [MODE_W-1:0] TONE_CLAMP    = 2'd0;
    localparam logic [MODE_W-1:0] TONE_REINHARD = 2'd1;
    localparam logic [MODE_W-1:0] TONE_ACES     = 2'd2;

    localparam logic [IDX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_MODE = 2'd1;
    localparam logic [IDX_W-1:0] REG_SRGB = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [MODE_W-1:0] mode;
        logic              srgb;
    } cfg_t;

    typedef struct packed {
        logic [RB-1:0]    y;
        logic [SQ2_W-1:0] y2;
    } sq_t;

    typedef struct packed {
        logic [RB-1:0]    y;
        logic [SQ2_W-1:0] y2;
        logic [CB3_W-1:0] y3;
    } cb_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QB-1:0]    q;
    } dv_t;

    // one restoring square root bit: try bit k on top of y
    function automatic sq_t sqrt_step(input int k, input logic [SQ_V_W-1:0] v,
                                      input sq_t s);
        logic [WIDE_W-1:0] trial;
        sq_t r;
        trial = WIDE_W'(s.y2) + (WIDE_W'(s.y) << (k + 1)) + (WIDE_W'(1) << (2 * k));
        r = s;
        if (trial <= WIDE_W'(v))
        begin
            r.y  = s.y | (RB'(1) << k);
            r.y2 = trial[SQ2_W-1:0];
        end
        return r;
    endfunction

    // one cube root bit: (y+b)^3 = y3 + 3 y2 b + 3 y b^2 + b^3, b = 2^k
    function automatic cb_t cbrt_step(input int k, input logic [CB_V_W-1:0] v,
                                      input cb_t s);
        logic [WIDE_W-1:0] t2;
        logic [WIDE_W-1:0] t3;
        cb_t r;
        t2 = WIDE_W'(s.y2) + (WIDE_W'(s.y) << (k + 1)) + (WIDE_W'(1) << (2 * k));
        t3 = WIDE_W'(s.y3) + ((WIDE_W'(s.y2) * 3) << k)
           + ((WIDE_W'(s.y) * 3) << (2 * k)) + (WIDE_W'(1) << (3 * k));
        r = s;
        if (t3 <= WIDE_W'(v))
        begin
            r.y  = s.y | (RB'(1) << k);
            r.y2 = t2[SQ2_W-1:0];
            r.y3 = t3[CB3_W-1:0];
        end
        return r;
    endfunction

    // one quotient bit of a restoring divider
    function automatic dv_t div_step(input int k, input logic [DEN_W-1:0] d,
                                     input dv_t s);
        logic [NUM_W-1:0] sh;
        dv_t r;
        sh = NUM_W'(d) << k;
        r = s;
        if (s.rem >= sh)
        begin
            r.rem = s.rem - sh;
            r.q   = s.q | (QB'(1) << k);
        end
        return r;
    endfunction

endpackage

// ===== hdl/hpt_chan.sv =====
module hpt_chan (
    input  logic                         clk,
    input  logic                         en,
    input  hpt_pkg::cfg_t                cfg,
    input  logic [hpt_pkg::PIX_W-1:0]    raw,
    output logic [hpt_pkg::BYTE_W-1:0]   byte_out
);
    import hpt_pkg::*;

    // front end: exposure, ACES polynomial products, divider operands
    logic [46:0]      s1_prod_reg;
    logic [X_W-1:0]   s2_x_reg;
    logic [X_W-1:0]   s3_x_reg;
    logic [36:0]      s3_ma_reg, s3_mb_reg;
    logic             s3_big_reg;
    logic [X_W-1:0]   s4_x_reg;
    logic [21:0]      s4_a_reg, s4_b_reg;
    logic             s4_big_reg;
    logic [X_W-1:0]   s5_x_reg;
    logic [40:0]      s5_num_reg;
    logic [DEN_W-1:0] s5_den_reg;
    logic             s5_big_reg;
    logic [NUM_W-1:0] s6_n_reg;
    logic [DEN_W-1:0] s6_d_reg;
    logic [T_W-1:0]   s6_tdir_reg;
    logic             s6_div_reg, s6_force_reg;

    logic             pos;
    logic [30:0]      s2_hi;
    logic [DEN_W-1:0] s6_d_next;
    logic [NUM_W-1:0] s6_n_next;
    logic             aces;

    assign pos   = !raw[PIX_W-1] && (raw != '0);
    assign s2_hi = s1_prod_reg[46:16];
    assign aces  = !(cfg.mode == TONE_CLAMP || cfg.mode == TONE_REINHARD);

    always_comb
    begin
        if (aces)
        begin
            s6_d_next = s5_den_reg;
            s6_n_next = (NUM_W'(s5_num_reg) << 16) + NUM_W'(s5_den_reg >> 1);
        end
        else
        begin
            s6_d_next = DEN_W'(s5_x_reg) + DEN_W'(ONE_Q16);
            s6_n_next = (NUM_W'(s5_x_reg) << 16) + NUM_W'(s6_d_next >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= pos ? (47'(raw[PIX_W-2:0]) * 47'(cfg.gain)) : '0;
            s2_x_reg    <= (s2_hi > 31'(MAX_X)) ? MAX_X : s2_hi[X_W-1:0];
            s3_x_reg    <= s2_x_reg;
            s3_ma_reg   <= 37'(ACES_A) * 37'(s2_x_reg[18:0]);
            s3_mb_reg   <= 37'(ACES_C) * 37'(s2_x_reg[18:0]);
            s3_big_reg  <= (s2_x_reg[X_W-1:19] != '0);
            s4_x_reg    <= s3_x_reg;
            s4_a_reg    <= 22'(s3_ma_reg[36:16]) + ACES_B;
            s4_b_reg    <= 22'(s3_mb_reg[36:16]) + ACES_D;
            s4_big_reg  <= s3_big_reg;
            s5_x_reg    <= s4_x_reg;
            s5_num_reg  <= 41'(s4_a_reg) * 41'(s4_x_reg[18:0]);
            s5_den_reg  <= DEN_W'(s4_b_reg) * DEN_W'(s4_x_reg[18:0]) + ACES_E;
            s5_big_reg  <= s4_big_reg;
            s6_n_reg    <= s6_n_next;
            s6_d_reg    <= s6_d_next;
            s6_tdir_reg <= (s5_x_reg > X_W'(ONE_Q16)) ? ONE_Q16 : s5_x_reg[T_W-1:0];
            s6_div_reg  <= (cfg.mode != TONE_CLAMP);
            s6_force_reg <= aces && s5_big_reg;
        end
    end

    // divider: overflow check, then one quotient bit per stage
    dv_t              dv_reg   [0:QB];
    logic [DEN_W-1:0] dd_reg   [0:QB];
    logic [T_W-1:0]   dt_reg   [0:QB];
    logic             ddiv_reg [0:QB];
    logic             dsat_reg [0:QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].rem <= s6_n_reg;
            dv_reg[0].q   <= '0;
            dd_reg[0]     <= s6_d_reg;
            dt_reg[0]     <= s6_tdir_reg;
            ddiv_reg[0]   <= s6_div_reg;
            dsat_reg[0]   <= s6_force_reg || (s6_n_reg >= (NUM_W'(s6_d_reg) << QB));
        end
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[i+1]   <= div_step(QB - 1 - i, dd_reg[i], dv_reg[i]);
                dd_reg[i+1]   <= dd_reg[i];
                dt_reg[i+1]   <= dt_reg[i];
                ddiv_reg[i+1] <= ddiv_reg[i];
                dsat_reg[i+1] <= dsat_reg[i];
            end
        end
    end

    logic [T_W-1:0] t_reg;
    logic [T_W-1:0] q_fin;

    assign q_fin = dv_reg[QB].q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!ddiv_reg[QB])
                t_reg <= dt_reg[QB];
            else if (dsat_reg[QB] || q_fin > ONE_Q16)
                t_reg <= ONE_Q16;
            else
                t_reg <= q_fin;
        end
    end

    // first row: sqrt(t<<16) and cbrt(t<<32)
    sq_t              ra_reg  [0:RB];
    cb_t              ca_reg  [0:RB];
    logic [T_W-1:0]   ta_reg  [0:RB];

    always_comb
    begin
        ra_reg[0] = '0;
        ca_reg[0] = '0;
        ta_reg[0] = t_reg;
    end

    for (genvar i = 0; i < RB; i++)
    begin : g_root_a
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[i+1] <= sqrt_step(RB - 1 - i, SQ_V_W'(ta_reg[i]) << 16, ra_reg[i]);
                ca_reg[i+1] <= cbrt_step(RB - 1 - i, CB_V_W'(ta_reg[i]) << 32, ca_reg[i]);
                ta_reg[i+1] <= ta_reg[i];
            end
        end
    end

    // second row: square roots of the first results, giving t^(1/4), t^(1/6)
    sq_t              rb_reg  [0:RB];
    sq_t              cbq_reg [0:RB];
    logic [RB-1:0]    ra_y_reg [0:RB];
    logic [RB-1:0]    ca_y_reg [0:RB];
    logic [T_W-1:0]   tb_reg  [0:RB];

    always_comb
    begin
        rb_reg[0]   = '0;
        cbq_reg[0]  = '0;
        ra_y_reg[0] = ra_reg[RB].y;
        ca_y_reg[0] = ca_reg[RB].y;
        tb_reg[0]   = ta_reg[RB];
    end

    for (genvar i = 0; i < RB; i++)
    begin : g_root_b
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rb_reg[i+1]   <= sqrt_step(RB - 1 - i, SQ_V_W'(ra_y_reg[i]) << 16, rb_reg[i]);
                cbq_reg[i+1]  <= sqrt_step(RB - 1 - i, SQ_V_W'(ca_y_reg[i]) << 16, cbq_reg[i]);
                ra_y_reg[i+1] <= ra_y_reg[i];
                ca_y_reg[i+1] <= ca_y_reg[i];
                tb_reg[i+1]   <= tb_reg[i];
            end
        end
    end

    // back end: t^(5/12), 1.055 scale, offset, linear segment at the knee, byte rounding
    logic [33:0]    e1_prod_reg;
    logic [11:0]    e1_lin_reg;
    logic           e1_lo_reg;
    logic [T_W-1:0] e1_t_reg;
    logic [T_W-1:0] e2_p_reg;
    logic [11:0]    e2_lin_reg;
    logic           e2_lo_reg;
    logic [T_W-1:0] e2_t_reg;
    logic [33:0]    e3_m_reg;
    logic [11:0]    e3_lin_reg;
    logic           e3_lo_reg;
    logic [T_W-1:0] e3_t_reg;
    logic [T_W-1:0] e4_v_reg;
    logic [BYTE_W-1:0] byte_reg;

    logic [T_W-1:0] tq;
    logic [27:0]    lin_full;
    logic [33:0]    p_full;
    logic [17:0]    vh;
    logic [17:0]    vs;
    logic [T_W-1:0] v_next;
    logic [24:0]    byte_full;

    assign tq        = tb_reg[RB];
    assign lin_full  = 28'(tq[7:0]) * 28'(SRGB_LIN) + 28'd32768;
    assign p_full    = e1_prod_reg + 34'd32768;
    assign vh        = 18'((e3_m_reg + 34'd32768) >> 16);
    assign vs        = (vh > SRGB_OFS) ? (vh - SRGB_OFS) : '0;
    assign byte_full = 25'(e4_v_reg) * 25'd255 + 25'd32768;

    always_comb
    begin
        if (!cfg.srgb)
            v_next = e3_t_reg;
        else if (e3_lo_reg)
            v_next = T_W'(e3_lin_reg);
        else if (vs > 18'(ONE_Q16))
            v_next = ONE_Q16;
        else
            v_next = vs[T_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_prod_reg <= 34'(rb_reg[RB].y) * 34'(cbq_reg[RB].y);
            e1_lin_reg  <= lin_full[27:16];
            e1_lo_reg   <= (tq <= SRGB_KNEE);
            e1_t_reg    <= tq;
            e2_p_reg    <= p_full[32:16];
            e2_lin_reg  <= e1_lin_reg;
            e2_lo_reg   <= e1_lo_reg;
            e2_t_reg    <= e1_t_reg;
            e3_m_reg    <= 34'(SRGB_GAIN) * 34'(e2_p_reg);
            e3_lin_reg  <= e2_lin_reg;
            e3_lo_reg   <= e2_lo_reg;
            e3_t_reg    <= e2_t_reg;
            e4_v_reg    <= v_next;
            byte_reg    <= byte_full[23:16];
        end
    end

    assign byte_out = byte_reg;

endmodule

// ===== hdl/hdr_pixel_tonemap_srgb_core.sv =====
// An accepted input transaction reaches the output through the LAT pipeline stages.
// Throughput: one pixel per cycle; the whole pipeline advances as one unit and
//   holds only while a finished pixel sits in the output register under stall.
// Reset (rst_n, async, active low) clears all valid bits and loads the register
//   defaults: exposure gain 1.0, ACES curve, sRGB encode on. No clearing pass.
module hdr_pixel_tonemap_srgb_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [hpt_pkg::IDX_W-1:0]     cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]     cfg_data,
    // input pixel channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hpt_pkg::PIX_W-1:0]     red_in,
    input  logic [hpt_pkg::PIX_W-1:0]     green_in,
    input  logic [hpt_pkg::PIX_W-1:0]     blue_in,
    input  logic [hpt_pkg::PIX_W-1:0]     alpha_in,
    // output pixel channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hpt_pkg::BYTE_W-1:0]    red_out,
    output logic [hpt_pkg::BYTE_W-1:0]    green_out,
    output logic [hpt_pkg::BYTE_W-1:0]    blue_out,
    output logic [hpt_pkg::BYTE_W-1:0]    alpha_out
);
    import hpt_pkg::*;

    // Configuration registers, read directly by every stage. The user must let writes
    // land only while the pipe is empty; the block itself does not enforce this.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain <= GAIN_RST;
            cfg_reg.mode <= TONE_ACES;
            cfg_reg.srgb <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN: cfg_reg.gain <= cfg_data[GAIN_W-1:0];
                REG_MODE: cfg_reg.mode <= cfg_data[MODE_W-1:0];
                REG_SRGB: cfg_reg.srgb <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    // Global advance: the pipe moves unless the last stage holds a
    // transaction the sink is stalling. Bubbles move through with it.
    logic en;
    logic vld_reg [0:LAT-1];

    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Color channels: exposure, tone curve (divider), sRGB roots, byte.
    hpt_chan u_red (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .raw      (red_in),
        .byte_out (red_out)
    );

    hpt_chan u_green (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .raw      (green_in),
        .byte_out (green_out)
    );

    hpt_chan u_blue (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .raw      (blue_in),
        .byte_out (blue_out)
    );

    // Alpha: clamp to 0..1, round to a byte at entry, then delay to line up.
    logic [T_W-1:0]    alpha_c;
    logic [24:0]       alpha_full;
    logic [BYTE_W-1:0] alpha_reg [0:LAT-1];

    always_comb
    begin
        if (alpha_in[PIX_W-1] || alpha_in == '0)
            alpha_c = '0;
        else if (alpha_in >= PIX_W'(ONE_Q16))
            alpha_c = ONE_Q16;
        else
            alpha_c = alpha_in[T_W-1:0];
    end

    assign alpha_full = 25'(alpha_c) * 25'd255 + 25'd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg[0] <= alpha_full[23:16];
            for (int i = 1; i < LAT; i++)
                alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign alpha_out = alpha_reg[LAT-1];

endmodule

// ===== sim/hpt_checker.sv =====
module hpt_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [hpt_pkg::IDX_W-1:0]  cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [hpt_pkg::PIX_W-1:0]  red_in,
    input  logic [hpt_pkg::PIX_W-1:0]  green_in,
    input  logic [hpt_pkg::PIX_W-1:0]  blue_in,
    input  logic [hpt_pkg::PIX_W-1:0]  alpha_in,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [hpt_pkg::BYTE_W-1:0] red_out,
    input  logic [hpt_pkg::BYTE_W-1:0] green_out,
    input  logic [hpt_pkg::BYTE_W-1:0] blue_out,
    input  logic [hpt_pkg::BYTE_W-1:0] alpha_out,
    output int                         pending,
    output int                         failures
);
    import hpt_pkg::*;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba8_t;

    logic [GAIN_W-1:0] gain_q;
    logic [MODE_W-1:0] mode_q;
    logic              srgb_q;
    rgba8_t            display_q[$];

    function automatic logic [7:0] quantize(logic [63:0] v);
        logic [63:0] w;
        w = (v * 255 + 32768) >> 16;
        return w[7:0];
    endfunction

    // largest y in 0..65536 with y^2 (or y^3) <= v
    function automatic logic [63:0] floor_root(logic [63:0] v, bit cube);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] pw;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            pw = mid * mid;
            if (cube)
                pw = pw * mid;
            if (pw <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [63:0] curve(logic [63:0] x);
        logic [63:0] d;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] t;
        if (mode_q == TONE_CLAMP)
            return (x > 65536) ? 64'd65536 : x;
        if (mode_q == TONE_REINHARD)
        begin
            d = x + 65536;
            return ((x << 16) + d / 2) / d;
        end
        // ACES, also for the unused mode code
        if (x >= (64'd8 << 16))
            return 64'd65536;
        a = ((64'd164495 * x) >> 16) + 1966;
        b = ((64'd159252 * x) >> 16) + 38666;
        num = a * x;
        den = b * x + (64'd9175 << 16);
        t = ((num << 16) + den / 2) / den;
        return (t > 65536) ? 64'd65536 : t;
    endfunction

    function automatic logic [63:0] srgb_gamma(logic [63:0] t);
        logic [63:0] q4;
        logic [63:0] q6;
        logic [63:0] p;
        logic [63:0] v;
        if (t <= 205)
            return (t * 846725 + 32768) >> 16;
        q4 = floor_root(floor_root(t << 16, 0) << 16, 0);
        q6 = floor_root(floor_root(t << 32, 1) << 16, 0);
        p = (q4 * q6 + 32768) >> 16;
        v = (64'd69140 * p + 32768) >> 16;
        v = (v > 3604) ? v - 3604 : 64'd0;
        return (v > 65536) ? 64'd65536 : v;
    endfunction

    function automatic logic [7:0] color_byte(logic [PIX_W-1:0] raw);
        logic signed [PIX_W-1:0] s;
        logic [63:0] x;
        logic [63:0] t;
        s = raw;
        if (s <= 0)
            x = 0;
        else
        begin
            x = (64'(s) * 64'(gain_q)) >> 16;
            if (x > 64'h7FFFFF)
                x = 64'h7FFFFF;
        end
        t = curve(x);
        if (srgb_q)
            t = srgb_gamma(t);
        return quantize(t);
    endfunction

    function automatic rgba8_t tonemap_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                             logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
        rgba8_t p;
        logic signed [PIX_W-1:0] sa;
        logic [63:0] av;
        sa = a;
        if (sa <= 0)
            av = 0;
        else if (sa >= 65536)
            av = 65536;
        else
            av = 64'(sa);
        p.r = color_byte(r);
        p.g = color_byte(g);
        p.b = color_byte(b);
        p.a = quantize(av);
        return p;
    endfunction

    assign pending = display_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rgba8_t want;
        rgba8_t got;
        if (!rst_n)
        begin
            gain_q <= GAIN_RST;
            mode_q <= TONE_ACES;
            srgb_q <= 1'b1;
            failures <= 0;
            display_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GAIN)
                    gain_q <= cfg_data[GAIN_W-1:0];
                else if (cfg_index == REG_MODE)
                    mode_q <= cfg_data[MODE_W-1:0];
                else if (cfg_index == REG_SRGB)
                    srgb_q <= cfg_data[0];
            end
            if (in_valid && !in_stall)
                display_q.push_back(tonemap_pixel(red_in, green_in, blue_in, alpha_in));
            if (out_valid && !out_stall)
            begin
                got = '{red_out, green_out, blue_out, alpha_out};
                if (display_q.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected output transaction %h", got);
                    failures <= failures + 1;
                end
                else
                begin
                    want = display_q.pop_front();
                    if (want !== got)
                    begin
                        if (failures < 10)
                            $display("mismatch rgba: expected %h actual %h", want, got);
                        failures <= failures + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb_hdr_pixel_tonemap_srgb_core.sv =====
module tb_hdr_pixel_tonemap_srgb_core;
    import hpt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 136;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [PIX_W-1:0]  red_in;
    logic [PIX_W-1:0]  green_in;
    logic [PIX_W-1:0]  blue_in;
    logic [PIX_W-1:0]  alpha_in;
    logic              out_valid;
    logic              out_stall;
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic [BYTE_W-1:0] alpha_out;

    int pending;
    int failures;
    int cycles;
    int stall_left;
    bit calm;          // last part of the run: no idling on either side
    bit took;          // input transaction accepted at the last rising edge

    hdr_pixel_tonemap_srgb_core dut (.*);

    hpt_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // acceptance flag, read by the sender at the falling edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            took <= 1'b0;
        else
            took <= in_valid && !in_stall;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // one input transaction, then an optional gap
    task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
        int gap;
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        alpha_in <= a;
        do
            @(negedge clk);
        while (!took);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // register write while the pipeline is drained
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        in_valid  <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // field extremes, sRGB knee, ACES cutoff, alpha limits
    task automatic send_corners();
        send_pixel(24'h000000, 24'h7FFFFF, 24'h800000, 24'h000000);
        send_pixel(24'hFFFFFF, 24'h000001, 24'h010000, 24'h010000);
        send_pixel(24'd205, 24'd206, 24'd204, 24'h010001);
        send_pixel(24'h080000, 24'h07FFFF, 24'h00FFFF, 24'h00FFFF);
        send_pixel(24'h0000CD, 24'h000080, 24'h7FFFFF, 24'h7FFFFF);
        send_pixel(24'h800000, 24'hFFFFFF, 24'h000000, 24'h800000);
        send_pixel(24'h074000, 24'h010001, 24'h008000, 24'hFFFFFF);
        send_pixel(24'h000001, 24'h0000CE, 24'h0FFFFF, 24'h000001);
    endtask

    function automatic logic [PIX_W-1:0] rand_channel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return PIX_W'($urandom_range(0, 24'h0A0000));    // the curved range
        else if (pick < 7)
            return PIX_W'($urandom_range(0, 24'h0003FF));    // near black, knee
        else if (pick < 8)
            return PIX_W'(-$signed($urandom_range(0, 24'h7FFFFF)));
        else
            return PIX_W'($urandom());
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return CFG_W'($urandom());
        else if (pick == 1)
            return CFG_W'($urandom_range(0, 24'h040000));
        else
            return CFG_W'($urandom_range(24'h004000, 24'h020000));
    endfunction

    initial
    begin
        logic [CFG_W-1:0] gain_set;
        logic [1:0]       mode_set;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_GAIN;
        cfg_data   = '0;
        in_valid   = 1'b0;
        red_in     = '0;
        green_in   = '0;
        blue_in    = '0;
        alpha_in   = '0;
        out_stall  = 1'b0;
        stall_left = 0;
        calm       = 1'b0;
        cycles     = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset defaults first: gain 1.0, ACES, sRGB on
        send_corners();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: gain_set = CFG_W'(24'h010000);
                1: gain_set = '0;
                2: gain_set = CFG_W'(24'hFFFFFF);
                default: gain_set = rand_gain();
            endcase
            mode_set = 2'(ph % 4);                 // code 3 goes to ACES too
            if (ph > 0)
            begin
                write_reg(REG_GAIN, gain_set);
                write_reg(REG_MODE, {22'($urandom()), mode_set});
                write_reg(REG_SRGB, {23'($urandom()), ph[0]});
                write_reg(2'd3, CFG_W'($urandom()));  // no such register
            end
            if (ph == 4)
                send_corners();
            if (ph == PHASES - 1)
                calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // mid-phase hold-off until the pipeline has drained
                if (ph == 5 && i == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    wait (pending == 0);
                    @(negedge clk);
                end
                send_pixel(rand_channel(), rand_channel(), rand_channel(),
                           $urandom_range(0, 1) ? PIX_W'($urandom_range(0, 24'h012000))
                                                : PIX_W'($urandom()));
            end
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (LAT + 16) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/hpt_pkg.sv
hdl/hpt_chan.sv
hdl/hdr_pixel_tonemap_srgb_core.sv
sim/hpt_checker.sv
sim/tb_hdr_pixel_tonemap_srgb_core.sv
